### rtl/fpll_pkg.sv
// ----------------------------------------------------------------------------
// fpll_pkg
// Shared types and fixed constants of the four-pole ladder low-pass filter.
// ----------------------------------------------------------------------------
`default_nettype none

package fpll_pkg;

	// configuration register widths
	localparam int POLE_GAIN_W = 17;
	localparam int POLE_FB_W   = 18;
	localparam int RES_GAIN_W  = 18;
	localparam int CFG_DATA_W  = 18;
	localparam int CFG_INDEX_W = 2;

	// coefficients as signed operands: one sign bit above the widest register
	localparam int COEF_W = 19;

	// serial digit of the multiplier and the divider
	localparam int DIGIT_W = 4;

	// divisor of the cubic soft clip term and the width of its remainder
	localparam int CLIP_DIVISOR = 6;
	localparam int CLIP_REM_W   = 3;

	// register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_POLE_GAIN     = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_POLE_FEEDBACK = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_RES_GAIN      = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_INVERT        = 2'd3;

	// request to the serial multiplier
	typedef struct packed {
		logic start;
		logic state_op;   // state by state product, otherwise coefficient by state
	} mul_ctl_t;

endpackage

`default_nettype wire

### rtl/fpll_in_if.sv
// ----------------------------------------------------------------------------
// fpll_in_if
// Sample stream into the filter: valid/ready handshake with one sample.
// ----------------------------------------------------------------------------
`default_nettype none

interface fpll_in_if #(
	parameter int W = 24
);
	logic                valid;
	logic                ready;
	logic signed [W-1:0] sample_in;

	modport source (output valid, output sample_in, input ready);
	modport sink   (input valid, input sample_in, output ready);
endinterface

`default_nettype wire

### rtl/fpll_out_if.sv
// ----------------------------------------------------------------------------
// fpll_out_if
// Sample stream out of the filter: valid/ready handshake with one sample.
// ----------------------------------------------------------------------------
`default_nettype none

interface fpll_out_if #(
	parameter int W = 24
);
	logic                valid;
	logic                ready;
	logic signed [W-1:0] sample_out;

	modport source (output valid, output sample_out, input ready);
	modport sink   (input valid, input sample_out, output ready);
endinterface

`default_nettype wire

### rtl/fpll_dmul.sv
// ----------------------------------------------------------------------------
// fpll_dmul
// Digit-serial signed multiplier, one 4-bit digit of the serial operand per
// cycle, least significant first; result floored by a fixed fraction shift.
// ----------------------------------------------------------------------------
`default_nettype none

module fpll_dmul #(
	parameter int AW     = 36,
	parameter int BW     = 32,
	parameter int RW     = 41,
	parameter int CDIG   = 5,
	parameter int SDIG   = 8,
	parameter int CSHIFT = 16,
	parameter int SSHIFT = 27
) (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire fpll_pkg::mul_ctl_t ctl,
	input  wire logic signed [AW-1:0] mcand,
	input  wire logic signed [BW-1:0] mplier,
	output logic                    done,
	output logic signed [RW-1:0]    prod
);

	localparam int DW  = fpll_pkg::DIGIT_W;
	localparam int CW  = $clog2(BW / DW + 1);
	localparam int CPW = AW + 1 + DW * CDIG;
	localparam int SPW = AW + 1 + DW * SDIG;

	logic signed [AW-1:0] a_q;
	logic [BW-1:0]        b_q;
	logic signed [AW:0]   hi_q;
	logic [BW-1:0]        lo_q;
	logic [CW-1:0]        left_q;
	logic                 state_op_q;
	logic                 busy_q;
	logic                 done_q;

	logic                 last;
	logic signed [DW:0]   dig;
	logic signed [AW+DW:0] pp;
	logic signed [AW+DW:0] psum;
	logic signed [CPW-1:0] pc;
	logic signed [SPW-1:0] ps;

	assign last = (left_q == CW'(1));
	// top digit of the sign-extended operand carries the sign
	assign dig  = last ? {b_q[DW-1], b_q[DW-1:0]} : {1'b0, b_q[DW-1:0]};
	assign pp   = (AW+DW+1)'(a_q) * (AW+DW+1)'(dig);
	assign psum = (AW+DW+1)'(hi_q) + pp;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			left_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				left_q <= ctl.state_op ? CW'(SDIG) : CW'(CDIG);
			end else if (busy_q) begin
				left_q <= left_q - CW'(1);
				if (last) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			a_q        <= mcand;
			b_q        <= mplier;
			hi_q       <= '0;
			state_op_q <= ctl.state_op;
		end else if (busy_q) begin
			hi_q <= psum[AW+DW:DW];
			lo_q <= {psum[DW-1:0], lo_q[BW-1:DW]};
			b_q  <= b_q >> DW;
		end
	end

	// low product bits have collected at the top of lo_q
	assign pc   = {hi_q, lo_q[BW-1 -: DW*CDIG]};
	assign ps   = {hi_q, lo_q[BW-1 -: DW*SDIG]};
	assign prod = state_op_q ? RW'(ps >>> SSHIFT) : RW'(pc >>> CSHIFT);
	assign done = done_q;

`ifndef SYNTHESIS
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.start |-> !busy_q)
		else $error("multiplier started while busy");

	a_last_done: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && last && !ctl.start) |=> (done_q && !busy_q))
		else $error("multiplier missed its final digit");
`endif

endmodule

`default_nettype wire

### rtl/fpll_div6.sv
// ----------------------------------------------------------------------------
// fpll_div6
// Digit-serial floor division by the clip divisor, one 4-bit digit per cycle,
// most significant first, for the cubic soft clip term.
// ----------------------------------------------------------------------------
`default_nettype none

module fpll_div6 #(
	parameter int N = 41
) (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      start,
	input  wire logic signed [N-1:0] dividend,
	output logic                     done,
	output logic signed [N-1:0]      quotient
);

	localparam int DW  = fpll_pkg::DIGIT_W;
	localparam int RMW = fpll_pkg::CLIP_REM_W;
	localparam int TW  = RMW + DW;
	localparam int WD  = (N + RMW + DW - 1) / DW;
	localparam int WW  = WD * DW;
	localparam int CW  = $clog2(WD + 1);

	logic [WW-1:0]  w_q;
	logic [RMW-1:0] r_q;
	logic [CW-1:0]  left_q;
	logic           busy_q;
	logic           done_q;

	logic [RMW-1:0] offs;
	logic [TW-1:0]  step;

	// one radix-16 digit: remainder below the divisor, so the digit quotient fits 4 bits
	function automatic logic [TW-1:0] div_digit(input logic [TW-1:0] t);
		logic [TW-1:0] rem;
		logic [DW-1:0] qd;
		rem = t;
		qd  = '0;
		for (int i = DW - 1; i >= 0; i--) begin
			if (rem >= TW'(fpll_pkg::CLIP_DIVISOR << i)) begin
				rem   = rem - TW'(fpll_pkg::CLIP_DIVISOR << i);
				qd[i] = 1'b1;
			end
		end
		return {qd, rem[RMW-1:0]};
	endfunction

	// adding divisor * 2^N keeps the dividend positive; the low N quotient bits are the floor
	assign offs = dividend[N-1] ? RMW'(fpll_pkg::CLIP_DIVISOR - 1) :
		RMW'(fpll_pkg::CLIP_DIVISOR);
	assign step = div_digit({r_q, w_q[WW-1 -: DW]});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			left_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				left_q <= CW'(WD);
			end else if (busy_q) begin
				left_q <= left_q - CW'(1);
				if (left_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			w_q <= WW'({offs, dividend});
			r_q <= '0;
		end else if (busy_q) begin
			w_q <= {w_q[WW-DW-1:0], step[TW-1:RMW]};
			r_q <= step[RMW-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = w_q[N-1:0];

endmodule

`default_nettype wire

### rtl/four_pole_ladder_lowpass_core.sv
// ----------------------------------------------------------------------------
// four_pole_ladder_lowpass_core
// Four-pole ladder low-pass filter with resonance feedback and cubic soft clip.
// ----------------------------------------------------------------------------
// Usage:
//   samples  : valid/ready stream of signed Q0.23 input samples
//   filtered : valid/ready stream of signed Q0.23 output samples, one per input
//   cfg_*    : write port for pole gain, pole feedback, resonance gain and
//              output inversion; write only while no sample is in flight
// Every sample runs nine coefficient products, two cube products and a
// division by six through one digit-serial multiplier and one digit-serial
// divider, 4 bits per cycle. One sample is worked on at a time, and the
// input is ready again only once the result has been stored in the output
// register. The output register lets the next sample be taken while the
// last result still waits; if it is still full when a new result is
// ready, the block holds until the receiver takes it. Reset clears all
// stage state and the registers, and empties the output.
// ----------------------------------------------------------------------------
`default_nettype none

module four_pole_ladder_lowpass_core #(
	parameter int SAMPLE_WIDTH   = 24,
	parameter int COEF_FRAC_BITS = 16,
	parameter int STATE_WIDTH    = 32
) (
	input  wire                                        clk,
	input  wire                                        arst_n,
	fpll_in_if.sink                                    samples,
	fpll_out_if.source                                 filtered,
	input  wire                                        cfg_en,
	input  wire logic [fpll_pkg::CFG_INDEX_W-1:0]      cfg_index,
	input  wire logic [fpll_pkg::CFG_DATA_W-1:0]       cfg_data
);

	localparam int SF   = STATE_WIDTH - 5;
	localparam int SPF  = SAMPLE_WIDTH - 1;
	localparam int SHU  = (SF >= SPF) ? 0 : SPF - SF;
	localparam int SHD  = (SF >= SPF) ? SF - SPF : 0;
	localparam int IW   = SAMPLE_WIDTH + SHD;
	localparam int OW   = STATE_WIDTH + 1 + SHU;
	// the square of the most negative state needs one bit above STATE_WIDTH+4
	localparam int AW   = STATE_WIDTH + 5;
	localparam int CDIG = (fpll_pkg::COEF_W + fpll_pkg::DIGIT_W - 1) / fpll_pkg::DIGIT_W;
	localparam int SDIG = (STATE_WIDTH + fpll_pkg::DIGIT_W - 1) / fpll_pkg::DIGIT_W;
	localparam int NDIG = (CDIG > SDIG) ? CDIG : SDIG;
	localparam int BW   = NDIG * fpll_pkg::DIGIT_W;
	localparam int RW   = STATE_WIDTH + 9;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_ISSUE = 3'd1;
	localparam logic [2:0] ST_WAIT  = 3'd2;
	localparam logic [2:0] ST_DIV   = 3'd3;
	localparam logic [2:0] ST_DONE  = 3'd4;

	// product sequence: resonance, then gain/feedback pairs per stage, then the square and the cube
	localparam logic [3:0] OP_RESON  = 4'd0;
	localparam logic [3:0] OP_SQUARE = 4'd9;
	localparam logic [3:0] OP_CUBE   = 4'd10;

	localparam logic [1:0] LAST_STAGE = 2'd3;

	logic [fpll_pkg::POLE_GAIN_W-1:0]      pole_gain_q;
	logic signed [fpll_pkg::POLE_FB_W-1:0] pole_fb_q;
	logic [fpll_pkg::RES_GAIN_W-1:0]       res_gain_q;
	logic                                  invert_q;

	logic signed [STATE_WIDTH-1:0] stage_out_q [4];
	logic signed [STATE_WIDTH-1:0] prev_in_q [4];

	logic [2:0]                     state_q;
	logic [3:0]                     op_q;
	logic                           ov_q;
	logic signed [STATE_WIDTH-1:0]  s_q;
	logic signed [STATE_WIDTH-1:0]  cur_q;
	logic signed [RW-1:0]           part_q;
	logic signed [STATE_WIDTH-1:0]  res_q;
	logic signed [SAMPLE_WIDTH-1:0] sample_out_q;

	fpll_pkg::mul_ctl_t             mul_ctl;
	logic signed [AW-1:0]           mul_a;
	logic signed [BW-1:0]           mul_b;
	logic                           mul_done;
	logic signed [RW-1:0]           mul_prod;
	logic                           div_start;
	logic                           div_done;
	logic signed [RW-1:0]           div_q;

	logic [3:0]                     op_m1;
	logic [1:0]                     sec;
	logic                           gain_op;
	logic                           fb_op;
	logic signed [STATE_WIDTH:0]    sum_in;
	logic signed [IW-1:0]           in_wide;
	logic signed [STATE_WIDTH-1:0]  in_conv;
	logic signed [STATE_WIDTH-1:0]  x_new;
	logic signed [STATE_WIDTH-1:0]  sec_new;
	logic signed [STATE_WIDTH-1:0]  clip_new;
	logic signed [STATE_WIDTH:0]    v_sgn;
	logic signed [OW-1:0]           v_wide;
	logic [OW-SAMPLE_WIDTH:0]       v_top;
	logic signed [SAMPLE_WIDTH-1:0] out_sat;
	logic                           accept;
	logic                           out_load;

	function automatic logic signed [STATE_WIDTH-1:0] sat_state(
		input logic signed [RW:0] v
	);
		logic [RW-STATE_WIDTH+1:0] top;
		top = v[RW:STATE_WIDTH-1];
		if (&top || ~|top)
			return v[STATE_WIDTH-1:0];
		return {v[RW], {(STATE_WIDTH-1){~v[RW]}}};
	endfunction

	assign accept   = samples.valid && samples.ready;
	assign out_load = (state_q == ST_DONE) && (!ov_q || filtered.ready);

	assign op_m1   = op_q - 4'd1;
	assign sec     = op_m1[2:1];
	assign gain_op = op_q[0] && (op_q < OP_SQUARE);
	assign fb_op   = !op_q[0] && (op_q != OP_RESON) && (op_q < OP_SQUARE);
	assign sum_in  = (STATE_WIDTH+1)'(cur_q) + (STATE_WIDTH+1)'(prev_in_q[sec]);

	// input sample into state format
	always_comb begin
		in_wide = IW'(samples.sample_in);
		in_wide = in_wide <<< SHD;
		in_wide = in_wide >>> SHU;
		in_conv = STATE_WIDTH'(in_wide);
	end

	assign x_new    = sat_state((RW+1)'(s_q) - (RW+1)'(mul_prod));
	assign sec_new  = sat_state((RW+1)'(part_q) - (RW+1)'(mul_prod));
	assign clip_new = sat_state((RW+1)'(cur_q) - (RW+1)'(div_q));

	// clipped last stage into sample format
	always_comb begin
		v_sgn  = invert_q ? -(STATE_WIDTH+1)'(res_q) : (STATE_WIDTH+1)'(res_q);
		v_wide = OW'(v_sgn);
		v_wide = v_wide <<< SHU;
		v_wide = v_wide >>> SHD;
		v_top  = v_wide[OW-1:SAMPLE_WIDTH-1];
		if (&v_top || ~|v_top)
			out_sat = v_wide[SAMPLE_WIDTH-1:0];
		else
			out_sat = {v_wide[OW-1], {(SAMPLE_WIDTH-1){~v_wide[OW-1]}}};
	end

	// operand selection for the shared multiplier
	always_comb begin
		mul_a = AW'(stage_out_q[LAST_STAGE]);
		mul_b = BW'(res_gain_q);
		if (op_q == OP_SQUARE) begin
			mul_a = AW'(cur_q);
			mul_b = BW'(cur_q);
		end else if (op_q == OP_CUBE) begin
			mul_a = AW'(part_q);
			mul_b = BW'(cur_q);
		end else if (gain_op) begin
			mul_a = AW'(sum_in);
			mul_b = BW'(pole_gain_q);
		end else if (fb_op) begin
			mul_a = AW'(stage_out_q[sec]);
			mul_b = BW'(pole_fb_q);
		end
	end

	assign mul_ctl.start    = (state_q == ST_ISSUE);
	assign mul_ctl.state_op = (op_q >= OP_SQUARE);
	assign div_start        = (state_q == ST_WAIT) && mul_done && (op_q == OP_CUBE);

	fpll_dmul #(
		.AW     (AW),
		.BW     (BW),
		.RW     (RW),
		.CDIG   (CDIG),
		.SDIG   (SDIG),
		.CSHIFT (COEF_FRAC_BITS),
		.SSHIFT (SF)
	) u_dmul (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mul_ctl),
		.mcand  (mul_a),
		.mplier (mul_b),
		.done   (mul_done),
		.prod   (mul_prod)
	);

	fpll_div6 #(
		.N (RW)
	) u_div6 (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (mul_prod),
		.done     (div_done),
		.quotient (div_q)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			op_q        <= OP_RESON;
			ov_q        <= 1'b0;
			pole_gain_q <= '0;
			pole_fb_q   <= '0;
			res_gain_q  <= '0;
			invert_q    <= 1'b0;
			for (int i = 0; i < 4; i++) begin
				stage_out_q[i] <= '0;
				prev_in_q[i]   <= '0;
			end
		end else begin
			if (cfg_en) begin
				case (cfg_index)
					fpll_pkg::REG_POLE_GAIN: begin
						pole_gain_q <= cfg_data[fpll_pkg::POLE_GAIN_W-1:0];
					end
					fpll_pkg::REG_POLE_FEEDBACK: begin
						pole_fb_q <= cfg_data[fpll_pkg::POLE_FB_W-1:0];
					end
					fpll_pkg::REG_RES_GAIN: begin
						res_gain_q <= cfg_data[fpll_pkg::RES_GAIN_W-1:0];
					end
					fpll_pkg::REG_INVERT: begin
						invert_q <= cfg_data[0];
					end
					default: begin
					end
				endcase
			end

			// a new result refills the output in the cycle the old one leaves
			if (out_load)
				ov_q <= 1'b1;
			else if (filtered.ready)
				ov_q <= 1'b0;

			case (state_q)
				ST_IDLE: begin
					if (samples.valid) begin
						state_q <= ST_ISSUE;
						op_q    <= OP_RESON;
					end
				end
				ST_ISSUE: begin
					state_q <= ST_WAIT;
				end
				ST_WAIT: begin
					if (mul_done) begin
						if (op_q == OP_CUBE) begin
							state_q <= ST_DIV;
						end else begin
							op_q    <= op_q + 4'd1;
							state_q <= ST_ISSUE;
						end
						if (fb_op) begin
							prev_in_q[sec]   <= cur_q;
							stage_out_q[sec] <= sec_new;
						end
					end
				end
				ST_DIV: begin
					if (div_done) begin
						stage_out_q[LAST_STAGE] <= clip_new;
						state_q                 <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			s_q <= in_conv;
		if ((state_q == ST_WAIT) && mul_done) begin
			if (op_q == OP_RESON)
				cur_q <= x_new;
			else if (gain_op || (op_q == OP_SQUARE))
				part_q <= mul_prod;
			else if (fb_op)
				cur_q <= sec_new;
		end
		if ((state_q == ST_DIV) && div_done)
			res_q <= clip_new;
		if (out_load)
			sample_out_q <= out_sat;
	end

	assign samples.ready       = (state_q == ST_IDLE);
	assign filtered.valid      = ov_q;
	assign filtered.sample_out = sample_out_q;

`ifndef SYNTHESIS
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_ISSUE) && (op_q == OP_RESON))
		else $error("accepted sample did not start the product sequence");

	a_mul_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		mul_done |-> (state_q == ST_WAIT))
		else $error("multiplier result arrived outside the wait state");

	a_div_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_DIV))
		else $error("divider result arrived outside the divide state");
`endif

endmodule

`default_nettype wire

### test/four_pole_ladder_lowpass_core_tb.sv
// ----------------------------------------------------------------------------
// four_pole_ladder_lowpass_core_tb
// Self-checking bench for the ladder low-pass core. Coefficient sets are
// loaded while the core is idle. Samples are streamed in with random gaps on
// either side, and every filtered sample is compared against a bit-exact
// fixed-point model of the four sections, the feedback path and the soft clip.
// ----------------------------------------------------------------------------
`default_nettype none

module four_pole_ladder_lowpass_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SAMPLE_W    = 24;
	localparam int COEF_FRAC   = 16;
	localparam int STATE_W     = 32;
	localparam int SAMPLE_FRAC = SAMPLE_W - 1;
	localparam int STATE_FRAC  = STATE_W - 5;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int TAIL_CYCLES    = 200;
	localparam int RANDOM_PHASES  = 12;
	localparam int PHASE_ITEMS    = 130;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic signed [127:0] wide_t;
	typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

	localparam sample_t SAMPLE_MAX = 24'h7fffff;
	localparam sample_t SAMPLE_MIN = 24'h800000;

	class ladder_scoreboard;
		longint  gain_p;
		longint  feedback_k;
		longint  resonance_q;
		bit      invert;
		longint  stage_val[4];
		longint  stage_delay[4];
		sample_t expected_out[$];
		int      mismatches;

		function void write_reg(logic [fpll_pkg::CFG_INDEX_W-1:0] index,
				logic [fpll_pkg::CFG_DATA_W-1:0] data);
			case (index)
				fpll_pkg::REG_POLE_GAIN:     gain_p = longint'(data[16:0]);
				fpll_pkg::REG_POLE_FEEDBACK: feedback_k = longint'(signed'(data[17:0]));
				fpll_pkg::REG_RES_GAIN:      resonance_q = longint'(data[17:0]);
				fpll_pkg::REG_INVERT:        invert = data[0];
				default: ;
			endcase
		endfunction

		// floor(a*b / 2^sh), clamped to 62 bits
		function longint scaled_product(longint a, longint b, int sh);
			wide_t prod;
			prod = (wide_t'(a) * wide_t'(b)) >>> sh;
			if (prod > wide_t'((64'sd1 <<< 61) - 1))
				return (64'sd1 <<< 61) - 1;
			if (prod < -wide_t'(64'sd1 <<< 61))
				return -(64'sd1 <<< 61);
			return longint'(prod);
		endfunction

		function longint clamp(longint v, int w);
			longint hi;
			hi = (64'sd1 <<< (w - 1)) - 1;
			if (v > hi)
				return hi;
			if (v < -hi - 1)
				return -hi - 1;
			return v;
		endfunction

		function longint filter_sample(sample_t sample);
			longint x;
			longint stage_in;
			longint next_val;
			longint cube;
			longint clipped;
			longint v;
			x = longint'(sample) <<< (STATE_FRAC - SAMPLE_FRAC);
			x = clamp(x - scaled_product(resonance_q, stage_val[3], COEF_FRAC), STATE_W);
			stage_in = x;
			for (int n = 0; n < 4; n++) begin
				next_val = clamp(scaled_product(gain_p, stage_in + stage_delay[n], COEF_FRAC)
					- scaled_product(feedback_k, stage_val[n], COEF_FRAC), STATE_W);
				stage_delay[n] = stage_in;
				stage_val[n] = next_val;
				stage_in = next_val;
			end
			cube = scaled_product(scaled_product(stage_in, stage_in, STATE_FRAC),
				stage_in, STATE_FRAC);
			// floor division of the cubic term
			if (cube >= 0)
				cube = cube / fpll_pkg::CLIP_DIVISOR;
			else
				cube = -((-cube + fpll_pkg::CLIP_DIVISOR - 1) / fpll_pkg::CLIP_DIVISOR);
			clipped = clamp(stage_in - cube, STATE_W);
			stage_val[3] = clipped;
			v = invert ? -clipped : clipped;
			v = clamp(v >>> (STATE_FRAC - SAMPLE_FRAC), SAMPLE_W);
			return v;
		endfunction

		function void note_sample(sample_t sample);
			longint v;
			v = filter_sample(sample);
			expected_out.push_back(v[SAMPLE_W-1:0]);
		endfunction

		function void check_sample(sample_t actual);
			sample_t want;
			if (expected_out.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected sample_out %0d with nothing outstanding", actual);
				return;
			end
			want = expected_out.pop_front();
			if (actual !== want) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch sample_out: expected %0d got %0d", want, actual);
			end
		endfunction

		function int pending();
			return expected_out.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_en;
	logic [fpll_pkg::CFG_INDEX_W-1:0] cfg_index;
	logic [fpll_pkg::CFG_DATA_W-1:0]  cfg_data;

	idle_mode_t idle_mode;
	ladder_scoreboard sb;
	int idle_cycles;

	fpll_in_if  #(.W(SAMPLE_W)) samples_ch ();
	fpll_out_if #(.W(SAMPLE_W)) filtered_ch ();

	four_pole_ladder_lowpass_core #(
		.SAMPLE_WIDTH  (SAMPLE_W),
		.COEF_FRAC_BITS(COEF_FRAC),
		.STATE_WIDTH   (STATE_W)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.samples  (samples_ch),
		.filtered (filtered_ch),
		.cfg_en   (cfg_en),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic bit sender_idles();
		return (idle_mode == IDLE_SENDER && $urandom_range(99) < 65) ||
			(idle_mode == IDLE_BOTH && $urandom_range(99) < 6);
	endfunction

	function automatic bit receiver_stalls();
		return (idle_mode == IDLE_RECEIVER && $urandom_range(99) < 65) ||
			(idle_mode == IDLE_BOTH && $urandom_range(99) < 6);
	endfunction

	function automatic sample_t random_sample();
		case ($urandom_range(9))
			0: return SAMPLE_MAX;
			1: return SAMPLE_MIN;
			2, 3: return sample_t'(int'($urandom_range(2047)) - 1024);
			default: return sample_t'($urandom());
		endcase
	endfunction

	// output side and watchdog
	always @(posedge clk) begin
		if (filtered_ch.valid === 1'b1 && filtered_ch.ready === 1'b1)
			sb.check_sample(filtered_ch.sample_out);
		if ((filtered_ch.valid === 1'b1 && filtered_ch.ready === 1'b1) ||
				(samples_ch.valid === 1'b1 && samples_ch.ready === 1'b1))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	task automatic apply_setting(input longint p, input longint k, input longint q,
			input bit inv);
		logic [fpll_pkg::CFG_INDEX_W-1:0] index_list[4];
		longint value_list[4];
		index_list = '{fpll_pkg::REG_POLE_GAIN, fpll_pkg::REG_POLE_FEEDBACK,
			fpll_pkg::REG_RES_GAIN, fpll_pkg::REG_INVERT};
		value_list = '{p, k, q, longint'(inv)};
		for (int i = 0; i < 4; i++) begin
			cfg_en    <= 1'b1;
			cfg_index <= index_list[i];
			cfg_data  <= value_list[i][fpll_pkg::CFG_DATA_W-1:0];
			sb.write_reg(index_list[i], value_list[i][fpll_pkg::CFG_DATA_W-1:0]);
			@(posedge clk);
		end
		cfg_en <= 1'b0;
	endtask

	task automatic send_samples(input sample_t values[$]);
		foreach (values[i]) begin
			if (sender_idles()) begin
				samples_ch.valid <= 1'b0;
				do @(posedge clk); while (sender_idles());
			end
			samples_ch.valid     <= 1'b1;
			samples_ch.sample_in <= values[i];
			do @(posedge clk); while (samples_ch.ready !== 1'b1);
			sb.note_sample(values[i]);
		end
		samples_ch.valid <= 1'b0;
	endtask

	task automatic wait_drained();
		while (sb.pending() != 0)
			@(posedge clk);
		@(posedge clk);
	endtask

	initial begin
		sample_t batch[$];
		longint p;
		sb = new;
		idle_mode = IDLE_NONE;
		idle_cycles = 0;
		arst_n = 1'b0;
		cfg_en = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		samples_ch.valid = 1'b0;
		samples_ch.sample_in = '0;
		filtered_ch.ready = 1'b0;
		fork
			forever begin
				@(posedge clk);
				filtered_ch.ready <= !receiver_stalls();
			end
		join_none
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// full gains drive every stage into saturation; the clip then pins at the
		// negative rail and inversion has to land on the positive one
		apply_setting(66355, -65536, 262143, 1'b1);
		batch = '{SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN,
			24'sd0, 24'sd1, -24'sd1, SAMPLE_MAX, SAMPLE_MIN, 24'sd0};
		send_samples(batch);
		wait_drained();

		// coefficients past their nominal bounds, no resonance
		apply_setting(131071, 131071, 0, 1'b0);
		batch = '{SAMPLE_MAX, SAMPLE_MIN, 24'h555555, 24'haaaaaa, 24'sd1, -24'sd1,
			24'sd0, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MIN, 24'sd0, 24'sd0};
		send_samples(batch);
		wait_drained();

		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			case (phase)
				0: apply_setting(0, 0, 0, 1'b0);
				1: apply_setting(66355, 65536, 262143, 1'b1);
				2: apply_setting(66355, -65536, 0, 1'b0);
				default: begin
					if (phase % 2 == 1) begin
						// usual tuning: k follows 2p - 1
						p = $urandom_range(33177);
						apply_setting(p, 2 * p - 65536, $urandom_range(262143),
							$urandom_range(1));
					end else begin
						apply_setting($urandom_range(66355),
							longint'($urandom_range(131072)) - 65536,
							$urandom_range(262143), $urandom_range(1));
					end
				end
			endcase
			idle_mode = idle_mode_t'(phase % 4);
			batch.delete();
			repeat (PHASE_ITEMS) batch.push_back(random_sample());
			send_samples(batch);
			wait_drained();
		end

		idle_mode = IDLE_NONE;
		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

`default_nettype wire
